### src/bgr_pkg.sv
`timescale 1ns / 1ps

package bgr_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_STORE_BYTES = 2048;
    localparam int DEF_MAX_SIDE    = 8;

    // Screen coordinate range of the origins
    localparam int COORD_BITS = 12;

    // Field widths
    localparam int ADDR_W     = 11;
    localparam int CHAR_W     = 8;
    localparam int ORIGIN_W   = 12;
    localparam int COLOR_W    = 32;
    localparam int PIXEL_W    = 13;
    localparam int SIDE_REG_W = 4;
    localparam int COUNT_W    = 9;

    // Working width of the address reducer: index times bytes per glyph,
    // plus a byte offset on top of a reduced base
    localparam int RED_W = 13;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT  = 2'd2;

    localparam logic [SIDE_REG_W-1:0] RST_GLYPH_WIDTH  = 4'd8;
    localparam logic [SIDE_REG_W-1:0] RST_GLYPH_HEIGHT = 4'd8;
    localparam logic [COUNT_W-1:0]    RST_GLYPH_COUNT  = 9'd256;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_DRAW  = 1'b1;

    // Keep the low COORD_BITS of an origin
    localparam logic [ORIGIN_W-1:0] ORIGIN_MASK =
        (COORD_BITS >= ORIGIN_W) ? {ORIGIN_W{1'b1}} : ORIGIN_W'((1 << COORD_BITS) - 1);

    typedef struct packed {
        logic                command;
        logic [ADDR_W-1:0]   store_address;
        logic [7:0]          store_byte;
        logic [CHAR_W-1:0]   char_index;
        logic [ORIGIN_W-1:0] origin_x;
        logic [ORIGIN_W-1:0] origin_y;
        logic [COLOR_W-1:0]  pen_color;
    } t_in_beat;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_x;
        logic [PIXEL_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last;
    } t_out_beat;

endpackage

### src/bitmap_glyph_renderer_core.sv
`timescale 1ns / 1ps

// Character generator with a byte-wide glyph store.
// Input channel (i_in_valid / o_in_stall, payload i_in_data): a write beat
// stores one byte of the glyph store; a draw beat renders one character.
// Output channel (o_out_valid / i_out_stall, payload o_out_data): one beat per
// set glyph bit, columns outer and rows inner, last set on the final pixel.
// Configuration: i_cfg_we writes glyph_width, glyph_height or glyph_count at
// index i_cfg_index; write only while the block is idle.
// After reset the store is swept to zero, one byte per cycle, across all
// STORE_BYTES addresses; o_in_stall stays high during the sweep.
// The block works on one beat at a time and stalls its input meanwhile.
// A write runs the shared address reducer for R steps (2 at default sizes),
// then stores its byte. A draw runs the reducer, fetches the B bytes of
// the glyph and walks its W*H bits, one bit per cycle while the output
// does not hold the walk, then flushes the reserved pixel.
// Draws out of range or with zero size emit nothing and are dropped in idle.
// The walk holds one found pixel in reserve to tag last; when the receiver
// stalls with the output register full, the walk waits on the next set bit.
module bitmap_glyph_renderer_core #(
    parameter int STORE_BYTES    = bgr_pkg::DEF_STORE_BYTES,
    parameter int MAX_GLYPH_SIDE = bgr_pkg::DEF_MAX_SIDE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  bgr_pkg::t_in_beat                i_in_data,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output bgr_pkg::t_out_beat               o_out_data,
    input  logic                             i_out_stall,
    input  logic                             i_cfg_we,
    input  logic [bgr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bgr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW        = $clog2(STORE_BYTES);
    localparam int SIDE_W    = $clog2(MAX_GLYPH_SIDE + 1);
    localparam int BM_BYTES  = (MAX_GLYPH_SIDE * MAX_GLYPH_SIDE + 7) / 8;
    localparam int BM_BITS   = BM_BYTES * 8;
    localparam int BIT_W     = $clog2(BM_BITS);
    localparam int OFF_W     = (BM_BYTES > 1) ? $clog2(BM_BYTES) : 1;
    localparam int CNT_W     = $clog2(BM_BYTES + 1);
    localparam int PROD_W    = bgr_pkg::CHAR_W + CNT_W;
    localparam int RED_W     = bgr_pkg::RED_W;
    localparam int SB_LOG    = $clog2(STORE_BYTES + 1) - 1;
    localparam int RED_STEPS = (RED_W > SB_LOG) ? RED_W - SB_LOG : 1;
    localparam int STEP_W    = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
    localparam int PIXEL_W   = bgr_pkg::PIXEL_W;
    localparam int ORIGIN_W  = bgr_pkg::ORIGIN_W;

    localparam logic [AW-1:0]     CLR_LAST   = AW'(STORE_BYTES - 1);
    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(RED_STEPS - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_REDUCE = 3'd2;
    localparam logic [2:0] ST_FETCH  = 3'd3;
    localparam logic [2:0] ST_WALK   = 3'd4;
    localparam logic [2:0] ST_FLUSH  = 3'd5;

    // Control state
    logic [2:0]                        r_state, n_state;
    logic [AW-1:0]                     r_clr_addr, n_clr_addr;
    logic [bgr_pkg::SIDE_REG_W-1:0]    r_glyph_width, n_glyph_width;
    logic [bgr_pkg::SIDE_REG_W-1:0]    r_glyph_height, n_glyph_height;
    logic [bgr_pkg::COUNT_W-1:0]       r_glyph_count, n_glyph_count;
    logic                              r_rd_pend, n_rd_pend;
    logic                              r_pend_valid, n_pend_valid;
    logic                              r_out_valid, n_out_valid;

    // Working registers
    logic                              r_is_draw, n_is_draw;
    logic [RED_W-1:0]                  r_val, n_val;
    logic [STEP_W-1:0]                 r_step, n_step;
    logic [RED_W-1:0]                  r_base, n_base;
    logic [7:0]                        r_byte_wr, n_byte_wr;
    logic [SIDE_W-1:0]                 r_w, n_w;
    logic [SIDE_W-1:0]                 r_h, n_h;
    logic [CNT_W-1:0]                  r_bpg, n_bpg;
    logic [CNT_W-1:0]                  r_off, n_off;
    logic [OFF_W-1:0]                  r_rd_off, n_rd_off;
    logic [BM_BYTES-1:0][7:0]          r_bitmap, n_bitmap;
    logic [SIDE_W-1:0]                 r_x, n_x;
    logic [SIDE_W-1:0]                 r_y, n_y;
    logic [BIT_W-1:0]                  r_bit, n_bit;
    logic [ORIGIN_W-1:0]               r_ox, n_ox;
    logic [ORIGIN_W-1:0]               r_oy, n_oy;
    logic [bgr_pkg::COLOR_W-1:0]       r_color, n_color;
    logic [PIXEL_W-1:0]                r_pend_x, n_pend_x;
    logic [PIXEL_W-1:0]                r_pend_y, n_pend_y;
    bgr_pkg::t_out_beat                r_out_data, n_out_data;

    // Combinational helpers
    logic [SIDE_W-1:0]                 w_clamp;
    logic [SIDE_W-1:0]                 h_clamp;
    logic [2*SIDE_W-1:0]               glyph_bits;
    logic [CNT_W-1:0]                  bpg_calc;
    logic [PROD_W-1:0]                 base_raw;
    logic                              draw_ok;
    logic [RED_W-1:0]                  unit_val;
    logic [STEP_W-1:0]                 unit_shift;
    logic [RED_W-1:0]                  unit_out;
    logic                              st_we;
    logic [AW-1:0]                     st_waddr;
    logic [7:0]                        st_wdata;
    logic [AW-1:0]                     st_raddr;
    logic [7:0]                        st_rdata;
    logic [BM_BITS-1:0]                bm_flat;
    logic                              hit;
    logic                              out_free;

    bgr_store #(
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    bgr_modsub #(
        .STORE_BYTES (STORE_BYTES),
        .VAL_W       (RED_W),
        .SHIFT_W     (STEP_W)
    ) u_modsub (
        .i_val   (unit_val),
        .i_shift (unit_shift),
        .o_val   (unit_out)
    );

    // Saturate glyph sides and size up one glyph
    assign w_clamp = (r_glyph_width > bgr_pkg::SIDE_REG_W'(MAX_GLYPH_SIDE))
                   ? SIDE_W'(MAX_GLYPH_SIDE) : SIDE_W'(r_glyph_width);
    assign h_clamp = (r_glyph_height > bgr_pkg::SIDE_REG_W'(MAX_GLYPH_SIDE))
                   ? SIDE_W'(MAX_GLYPH_SIDE) : SIDE_W'(r_glyph_height);
    assign glyph_bits = (2*SIDE_W)'(w_clamp) * (2*SIDE_W)'(h_clamp);
    assign bpg_calc   = CNT_W'((glyph_bits + (2*SIDE_W)'(7)) >> 3);
    assign base_raw   = PROD_W'(i_in_data.char_index) * PROD_W'(bpg_calc);
    assign draw_ok    = ({1'b0, i_in_data.char_index} < r_glyph_count)
                     && (w_clamp != '0) && (h_clamp != '0);

    // Share the reducer between the address steps and the byte fetch
    assign unit_val   = (r_state == ST_FETCH) ? (r_base + RED_W'(r_off)) : r_val;
    assign unit_shift = (r_state == ST_FETCH) ? '0 : r_step;

    assign bm_flat  = r_bitmap;
    assign hit      = bm_flat[r_bit];
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_clr_addr     = r_clr_addr;
        n_glyph_width  = r_glyph_width;
        n_glyph_height = r_glyph_height;
        n_glyph_count  = r_glyph_count;
        n_rd_pend      = r_rd_pend;
        n_pend_valid   = r_pend_valid;
        n_out_valid    = r_out_valid && i_out_stall;
        n_is_draw      = r_is_draw;
        n_val          = r_val;
        n_step         = r_step;
        n_base         = r_base;
        n_byte_wr      = r_byte_wr;
        n_w            = r_w;
        n_h            = r_h;
        n_bpg          = r_bpg;
        n_off          = r_off;
        n_rd_off       = r_rd_off;
        n_bitmap       = r_bitmap;
        n_x            = r_x;
        n_y            = r_y;
        n_bit          = r_bit;
        n_ox           = r_ox;
        n_oy           = r_oy;
        n_color        = r_color;
        n_pend_x       = r_pend_x;
        n_pend_y       = r_pend_y;
        n_out_data     = r_out_data;
        st_we          = 1'b0;
        st_waddr       = r_clr_addr;
        st_wdata       = 8'd0;
        st_raddr       = AW'(unit_out);

        // Register writes
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                bgr_pkg::CFG_GLYPH_WIDTH:  n_glyph_width  = i_cfg_data[3:0];
                bgr_pkg::CFG_GLYPH_HEIGHT: n_glyph_height = i_cfg_data[3:0];
                bgr_pkg::CFG_GLYPH_COUNT:  n_glyph_count  = i_cfg_data;
                default: ;
            endcase
        end

        // Capture the byte read in the previous cycle
        if (r_rd_pend) begin
            n_bitmap[r_rd_off] = st_rdata;
        end

        unique case (r_state)
            ST_CLEAR: begin
                st_we      = 1'b1;
                st_waddr   = r_clr_addr;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (i_in_valid) begin
                    n_step = STEP_FIRST;
                    if (i_in_data.command == bgr_pkg::CMD_WRITE) begin
                        n_is_draw = 1'b0;
                        n_val     = RED_W'(i_in_data.store_address);
                        n_byte_wr = i_in_data.store_byte;
                        n_state   = ST_REDUCE;
                    end else if (draw_ok) begin
                        n_is_draw = 1'b1;
                        n_val     = RED_W'(base_raw);
                        n_w       = w_clamp;
                        n_h       = h_clamp;
                        n_bpg     = bpg_calc;
                        n_ox      = i_in_data.origin_x & bgr_pkg::ORIGIN_MASK;
                        n_oy      = i_in_data.origin_y & bgr_pkg::ORIGIN_MASK;
                        n_color   = i_in_data.pen_color;
                        n_state   = ST_REDUCE;
                    end
                end
            end

            ST_REDUCE: begin
                n_val = unit_out;
                if (r_step == '0) begin
                    if (r_is_draw) begin
                        n_base  = unit_out;
                        n_off   = '0;
                        n_state = ST_FETCH;
                    end else begin
                        st_we    = 1'b1;
                        st_waddr = AW'(unit_out);
                        st_wdata = r_byte_wr;
                        n_state  = ST_IDLE;
                    end
                end else begin
                    n_step = r_step - STEP_W'(1);
                end
            end

            ST_FETCH: begin
                // Issue one byte read per cycle, then drain the last one
                if (r_off < r_bpg) begin
                    n_off     = r_off + CNT_W'(1);
                    n_rd_pend = 1'b1;
                    n_rd_off  = OFF_W'(r_off);
                end else begin
                    n_rd_pend = 1'b0;
                    if (!r_rd_pend) begin
                        n_x     = '0;
                        n_y     = '0;
                        n_bit   = '0;
                        n_state = ST_WALK;
                    end
                end
            end

            ST_WALK: begin
                // Hold while a found pixel meets a full output register
                if (!(hit && r_pend_valid && !out_free)) begin
                    if (hit) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_data  = '{pixel_x: r_pend_x, pixel_y: r_pend_y,
                                            pixel_color: r_color, last: 1'b0};
                        end
                        n_pend_valid = 1'b1;
                        n_pend_x     = PIXEL_W'(r_ox) + PIXEL_W'(r_x);
                        n_pend_y     = PIXEL_W'(r_oy) + PIXEL_W'(r_y);
                    end
                    if (r_y == r_h - SIDE_W'(1)) begin
                        n_y   = '0;
                        n_x   = r_x + SIDE_W'(1);
                        n_bit = BIT_W'(r_x) + BIT_W'(1);
                        if (r_x == r_w - SIDE_W'(1)) begin
                            n_state = ST_FLUSH;
                        end
                    end else begin
                        n_y   = r_y + SIDE_W'(1);
                        n_bit = r_bit + BIT_W'(r_w);
                    end
                end
            end

            ST_FLUSH: begin
                // Send the reserved pixel tagged as last
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = '{pixel_x: r_pend_x, pixel_y: r_pend_y,
                                     pixel_color: r_color, last: 1'b1};
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_clr_addr     <= '0;
            r_glyph_width  <= bgr_pkg::RST_GLYPH_WIDTH;
            r_glyph_height <= bgr_pkg::RST_GLYPH_HEIGHT;
            r_glyph_count  <= bgr_pkg::RST_GLYPH_COUNT;
            r_rd_pend      <= 1'b0;
            r_pend_valid   <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr_addr     <= n_clr_addr;
            r_glyph_width  <= n_glyph_width;
            r_glyph_height <= n_glyph_height;
            r_glyph_count  <= n_glyph_count;
            r_rd_pend      <= n_rd_pend;
            r_pend_valid   <= n_pend_valid;
            r_out_valid    <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_is_draw  <= n_is_draw;
        r_val      <= n_val;
        r_step     <= n_step;
        r_base     <= n_base;
        r_byte_wr  <= n_byte_wr;
        r_w        <= n_w;
        r_h        <= n_h;
        r_bpg      <= n_bpg;
        r_off      <= n_off;
        r_rd_off   <= n_rd_off;
        r_bitmap   <= n_bitmap;
        r_x        <= n_x;
        r_y        <= n_y;
        r_bit      <= n_bit;
        r_ox       <= n_ox;
        r_oy       <= n_oy;
        r_color    <= n_color;
        r_pend_x   <= n_pend_x;
        r_pend_y   <= n_pend_y;
        r_out_data <= n_out_data;
    end

endmodule

### src/bgr_store.sv
`timescale 1ns / 1ps

module bgr_store #(
    parameter int  DEPTH = bgr_pkg::DEF_STORE_BYTES,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/bgr_modsub.sv
`timescale 1ns / 1ps

module bgr_modsub #(
    parameter int STORE_BYTES = bgr_pkg::DEF_STORE_BYTES,
    parameter int VAL_W       = bgr_pkg::RED_W,
    parameter int SHIFT_W     = 1
) (
    input  logic [VAL_W-1:0]   i_val,
    input  logic [SHIFT_W-1:0] i_shift,
    output logic [VAL_W-1:0]   o_val
);

    localparam int SB_W = $clog2(STORE_BYTES + 1);
    localparam int CW   = (VAL_W > SB_W) ? VAL_W : SB_W;

    logic [CW-1:0]    shifted;
    logic             take_sub;
    logic [VAL_W-1:0] sub_amount;

    // Subtract STORE_BYTES scaled by 2^shift when it fits under the value
    assign shifted    = CW'(i_val >> i_shift);
    assign take_sub   = (shifted >= CW'(STORE_BYTES));
    assign sub_amount = VAL_W'(STORE_BYTES) << i_shift;
    assign o_val      = take_sub ? (i_val - sub_amount) : i_val;

endmodule

### src/bgr_checker.sv
`timescale 1ns / 1ps

module bgr_port_checks (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input bgr_pkg::t_in_beat  i_in_data,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input bgr_pkg::t_out_beat o_out_data,
    input logic               i_out_stall
);

    // Keep a stalled output beat valid
    a_out_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // Keep a stalled output beat unchanged
    a_out_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("output beat changed while stalled");

    // Start the store sweep after reset with the output empty
    a_reset_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_in_stall && !o_out_valid))
        else $error("block not sweeping or output not empty after reset");

    // Stay busy after an accepted write beat
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_data.command == bgr_pkg::CMD_WRITE))
        |=> o_in_stall)
        else $error("write beat did not occupy the block");

endmodule

bind bitmap_glyph_renderer_core bgr_port_checks u_bgr_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
